// File: rtl/ralu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralu_pkg
// Types and constants shared by the register ALU with NZCV flags.
// ----------------------------------------------------------------------------
package ralu_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned REG_SEL_W = 3;

  localparam logic [WORD_W-1:0] RESET_VALUE = 32'd100;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_MOV = 2'd3
  } mode_e;

  typedef struct packed {
    logic                 n;
    logic                 z;
    logic                 c;
    logic                 v;
  } flags_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [REG_SEL_W-1:0] dest_reg;
    logic [REG_SEL_W-1:0] source_reg;
    logic [WORD_W-1:0]    immediate;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]    result_value;
    logic                 flag_negative;
    logic                 flag_zero;
    logic                 flag_carry;
    logic                 flag_overflow;
    logic [CNT_W-1:0]     turn_count;
  } out_word_t;

endpackage

// File: rtl/ralu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralu_ram
// Generic RAM, one write port, two registered read ports sharing an enable.
// ----------------------------------------------------------------------------
module ralu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/ralu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralu_exec
// Combinational execute: add/sub immediate, multiply, move, with NZCV.
// ----------------------------------------------------------------------------
module ralu_exec import ralu_pkg::*; (
  input  logic [1:0]        mode_i,
  input  logic [WORD_W-1:0] op_a_i,
  input  logic [WORD_W-1:0] op_b_i,
  input  logic [WORD_W-1:0] imm_i,
  output logic [WORD_W-1:0] result_o,
  output flags_t            flags_o
);

  logic [WORD_W:0]     sum;
  logic [WORD_W:0]     diff;
  logic [2*WORD_W-1:0] prod;
  logic [WORD_W-1:0]   hi_s;
  logic [WORD_W-1:0]   corr_a;
  logic [WORD_W-1:0]   corr_b;
  logic [WORD_W-1:0]   res;
  logic                c;
  logic                v;

  assign sum    = {1'b0, op_a_i} + {1'b0, imm_i};
  assign diff   = {1'b0, op_a_i} - {1'b0, imm_i};
  assign prod   = (2*WORD_W)'(op_a_i) * (2*WORD_W)'(op_b_i);
  // signed high word = unsigned high word minus sign corrections
  assign corr_a = op_a_i[WORD_W-1] ? op_b_i : '0;
  assign corr_b = op_b_i[WORD_W-1] ? op_a_i : '0;
  assign hi_s   = prod[2*WORD_W-1:WORD_W] - corr_a - corr_b;

  always_comb begin
    res = imm_i;
    c   = 1'b0;
    v   = 1'b0;
    case (mode_e'(mode_i))
      MODE_ADD: begin
        res = sum[WORD_W-1:0];
        c   = sum[WORD_W];
        v   = ~(op_a_i[WORD_W-1] ^ imm_i[WORD_W-1]) & (op_a_i[WORD_W-1] ^ res[WORD_W-1]);
      end
      MODE_SUB: begin
        res = diff[WORD_W-1:0];
        c   = ~diff[WORD_W];
        v   = (op_a_i[WORD_W-1] ^ imm_i[WORD_W-1]) & (op_a_i[WORD_W-1] ^ res[WORD_W-1]);
      end
      MODE_MUL: begin
        res = prod[WORD_W-1:0];
        c   = |prod[2*WORD_W-1:WORD_W];
        v   = (hi_s != {WORD_W{prod[WORD_W-1]}});
      end
      MODE_MOV: begin
        res = imm_i;
      end
      default: begin
        res = imm_i;
      end
    endcase
  end

  assign result_o  = res;
  assign flags_o.n = res[WORD_W-1];
  assign flags_o.z = (res == '0);
  assign flags_o.c = c;
  assign flags_o.v = v;

endmodule

// File: rtl/register_alu_nzcv_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_alu_nzcv_flags
// Register-file ALU: one instruction per word, NZCV flags, instruction count.
// Words pass through the register file read, then execute into the output
// register. Throughput: one word per cycle while the output is not held off,
// set by the read-modify-write with write-to-read bypass.
// Reset: every register reads 100 (per-entry valid bits), count is zero,
// no clearing pass; the block accepts words straight after reset.
// ----------------------------------------------------------------------------
module register_alu_nzcv_flags import ralu_pkg::*; #(
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(REGISTER_COUNT);
  localparam logic [5:0]  RC6   = 6'(REGISTER_COUNT);

  // index modulo the register count by repeated compare-subtract
  function automatic logic [IDX_W-1:0] reg_index(input logic [REG_SEL_W-1:0] sel);
    logic [5:0] v;
    v = 6'(sel);
    for (int i = 0; i < 4; i++) begin
      if (v >= RC6) begin
        v = v - RC6;
      end
    end
    return v[IDX_W-1:0];
  endfunction

  logic                      accept;
  logic                      s1_advance;
  logic [IDX_W-1:0]          d_idx;
  logic [IDX_W-1:0]          s_idx;

  logic                      s1_valid_q;
  logic [1:0]                s1_mode_q;
  logic [WORD_W-1:0]         s1_imm_q;
  logic [IDX_W-1:0]          d_idx_q;
  logic [IDX_W-1:0]          s_idx_q;
  logic                      a_vld_q;
  logic                      b_vld_q;

  logic [REGISTER_COUNT-1:0] reg_vld_q;
  logic                      wb_vld_q;
  logic [IDX_W-1:0]          wb_idx_q;
  logic [WORD_W-1:0]         wb_data_q;

  logic [WORD_W-1:0]         rdata_a;
  logic [WORD_W-1:0]         rdata_b;
  logic [WORD_W-1:0]         op_a;
  logic [WORD_W-1:0]         op_b;
  logic [WORD_W-1:0]         exec_res;
  flags_t                    exec_flags;

  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          cnt_d;

  logic                      out_valid_q;
  out_word_t                 out_q;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign accept     = in_valid_i && in_ready_o;
  assign d_idx      = reg_index(in_data_i.dest_reg);
  assign s_idx      = reg_index(in_data_i.source_reg);
  assign cnt_d      = cnt_q + CNT_W'(1);

  ralu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (REGISTER_COUNT)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (s1_advance),
    .waddr_i   (d_idx_q),
    .wdata_i   (exec_res),
    .re_i      (accept),
    .raddr_a_i (d_idx),
    .raddr_b_i (s_idx),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // bypass covers the write landing on the same edge as the read
  always_comb begin
    if (wb_vld_q && (wb_idx_q == d_idx_q)) begin
      op_a = wb_data_q;
    end else begin
      op_a = a_vld_q ? rdata_a : RESET_VALUE;
    end
    if (wb_vld_q && (wb_idx_q == s_idx_q)) begin
      op_b = wb_data_q;
    end else begin
      op_b = b_vld_q ? rdata_b : RESET_VALUE;
    end
  end

  ralu_exec u_exec (
    .mode_i   (s1_mode_q),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .imm_i    (s1_imm_q),
    .result_o (exec_res),
    .flags_o  (exec_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      reg_vld_q   <= '0;
      wb_vld_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q        <= 1'b1;
        reg_vld_q[d_idx_q] <= 1'b1;
        wb_vld_q           <= 1'b1;
        cnt_q              <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= in_data_i.mode;
      s1_imm_q  <= in_data_i.immediate;
      d_idx_q   <= d_idx;
      s_idx_q   <= s_idx;
      a_vld_q   <= reg_vld_q[d_idx];
      b_vld_q   <= reg_vld_q[s_idx];
    end
    if (s1_advance) begin
      wb_idx_q               <= d_idx_q;
      wb_data_q              <= exec_res;
      out_q.result_value     <= exec_res;
      out_q.flag_negative    <= exec_flags.n;
      out_q.flag_zero        <= exec_flags.z;
      out_q.flag_carry       <= exec_flags.c;
      out_q.flag_overflow    <= exec_flags.v;
      out_q.turn_count       <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.flag_zero == (out_data_o.result_value == '0)))
    else $error("zero flag does not match result");

  a_neg_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.flag_negative == out_data_o.result_value[WORD_W-1]))
    else $error("negative flag does not match result");

  a_mov_cv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && (s1_mode_q == MODE_MOV)) |=>
      (!out_data_o.flag_carry && !out_data_o.flag_overflow))
    else $error("move left carry or overflow set");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> (out_data_o.turn_count == cnt_q))
    else $error("turn count out of step with delivered words");

endmodule

// File: tb/sv/ralu_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralu_check_pkg
// Scoreboard for the register ALU. It keeps a shadow register file and an
// instruction count, works out the expected output word for each accepted
// instruction, and checks every output word, field by field, against the
// oldest one still waiting.
// ----------------------------------------------------------------------------
package ralu_check_pkg;
  import ralu_pkg::*;

  localparam int unsigned REG_COUNT = 8;

  class alu_result_checker;
    logic [WORD_W-1:0] regs [REG_COUNT];
    logic [CNT_W-1:0]  turns;
    out_word_t         expected_results [$];
    int                fail_count;
    int                results_seen;

    function new();
      foreach (regs[i]) regs[i] = RESET_VALUE;
      turns        = '0;
      fail_count   = 0;
      results_seen = 0;
    endfunction

    function void note_instruction(in_word_t w);
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
      logic [WORD_W-1:0]   k;
      logic [WORD_W-1:0]   res;
      logic [WORD_W:0]     sum;
      logic [2*WORD_W-1:0] prod_u;
      longint              prod_s;
      int                  d;
      int                  s;
      out_word_t           o;
      d = int'(w.dest_reg) % REG_COUNT;
      s = int'(w.source_reg) % REG_COUNT;
      a = regs[d];
      b = regs[s];
      k = w.immediate;
      o = '0;
      case (mode_e'(w.mode))
        MODE_ADD: begin
          sum             = {1'b0, a} + {1'b0, k};
          res             = sum[WORD_W-1:0];
          o.flag_carry    = sum[WORD_W];
          o.flag_overflow = ~(a[WORD_W-1] ^ k[WORD_W-1]) & (a[WORD_W-1] ^ res[WORD_W-1]);
        end
        MODE_SUB: begin
          res             = a - k;
          o.flag_carry    = (a >= k);
          o.flag_overflow = (a[WORD_W-1] ^ k[WORD_W-1]) & (a[WORD_W-1] ^ res[WORD_W-1]);
        end
        MODE_MUL: begin
          prod_u          = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
          prod_s          = longint'($signed(a)) * longint'($signed(b));
          res             = prod_u[WORD_W-1:0];
          o.flag_carry    = |prod_u[2*WORD_W-1:WORD_W];
          // fits int32 only when bits 63..31 are all copies of the sign
          o.flag_overflow = (prod_s[63:31] != {33{prod_s[31]}});
        end
        default: begin
          res = k;
        end
      endcase
      turns           = turns + 1'b1;
      regs[d]         = res;
      o.result_value  = res;
      o.flag_negative = res[WORD_W-1];
      o.flag_zero     = (res == '0);
      o.turn_count    = turns;
      expected_results.push_back(o);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("output word with nothing expected: %p", got);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("flag_negative", want.flag_negative, got.flag_negative);
      compare_field("flag_zero", want.flag_zero, got.flag_zero);
      compare_field("flag_carry", want.flag_carry, got.flag_carry);
      compare_field("flag_overflow", want.flag_overflow, got.flag_overflow);
      compare_field("turn_count", want.turn_count, got.turn_count);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_register_alu_nzcv_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_alu_nzcv_flags
// Drives instruction words into the register ALU: a directed set covering
// carry, borrow, signed overflow, zero results and register squaring, then
// random instruction streams under three idle/stall mixes with long output
// back-pressure. Each output word is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_register_alu_nzcv_flags;
  import ralu_pkg::*;
  import ralu_check_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  alu_result_checker model;
  int                send_idle_pct;
  int                recv_stall_pct;

  register_alu_nzcv_flags #(
    .REGISTER_COUNT(REG_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("FAIL register_alu_nzcv_flags");
    $finish;
  end

  function automatic in_word_t make_word(mode_e m, int d, int s, logic [WORD_W-1:0] k);
    in_word_t w;
    w.mode       = m;
    w.dest_reg   = d[REG_SEL_W-1:0];
    w.source_reg = s[REG_SEL_W-1:0];
    w.immediate  = k;
    return w;
  endfunction

  function automatic in_word_t random_word();
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] edges [5];
    edges = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(9))
      0, 1, 2, 3: k = $urandom;
      4, 5:       k = $urandom_range(255);
      6:          k = edges[$urandom_range(4)];
      7:          k = -$urandom_range(1, 255);
      default:    k = $urandom >> $urandom_range(31);
    endcase
    return make_word(mode_e'($urandom_range(3)), $urandom_range(7), $urandom_range(7), k);
  endfunction

  // called and returns at a falling edge
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    model.note_instruction(w);
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_word(make_word(MODE_ADD, 0, 0, 32'h0));
    send_word(make_word(MODE_ADD, 0, 1, 32'hFFFF_FFFF));
    send_word(make_word(MODE_MOV, 1, 0, 32'h7FFF_FFFF));
    send_word(make_word(MODE_ADD, 1, 0, 32'h1));
    send_word(make_word(MODE_SUB, 2, 0, 32'd100));
    send_word(make_word(MODE_SUB, 2, 0, 32'h1));
    send_word(make_word(MODE_MOV, 3, 0, 32'h8000_0000));
    send_word(make_word(MODE_SUB, 3, 0, 32'h1));
    send_word(make_word(MODE_MUL, 2, 2, 32'hFFFF_FFFF));
    send_word(make_word(MODE_MOV, 4, 0, 32'h0001_0000));
    send_word(make_word(MODE_MUL, 4, 4, 32'h0));
    send_word(make_word(MODE_MOV, 5, 0, 32'hFFFF_FFFF));
    send_word(make_word(MODE_MOV, 6, 0, 32'h8000_0000));
    send_word(make_word(MODE_MUL, 5, 6, 32'h0));
    send_word(make_word(MODE_MOV, 7, 0, 32'h0));
    send_word(make_word(MODE_MUL, 0, 7, 32'h0));
    send_word(make_word(MODE_ADD, 7, 7, 32'hFFFF_FFFF));
    send_word(make_word(MODE_SUB, 7, 7, 32'hFFFF_FFFF));
    send_word(make_word(MODE_MUL, 1, 3, 32'h0));
    send_word(make_word(MODE_MOV, 6, 7, 32'hAAAA_5555));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      model.check_result(out_data_o);
    end
  end

  // output side; long hold-offs let the pipe fill and stall the input
  initial begin
    int hold_left;
    int hold_marks [$];
    hold_left   = 0;
    hold_marks  = {250, 1100};
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_marks.size() != 0 && model.results_seen >= hold_marks[0]) begin
        void'(hold_marks.pop_front());
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    model          = new();
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    rst_ni         = 1'b0;
    send_idle_pct  = 18;
    recv_stall_pct = 61;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (int i = 0; i < 430; i++) send_word(random_word());
    send_idle_pct  = 61;
    recv_stall_pct = 18;
    for (int i = 0; i < 430; i++) send_word(random_word());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 440; i++) send_word(random_word());
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (model.fail_count == 0) begin
      $display("PASS register_alu_nzcv_flags");
    end else begin
      $display("FAIL register_alu_nzcv_flags");
    end
    $finish;
  end

endmodule
